[rtl/core/khtg_pkg.sv]
// ----------------------------------------------------------------------------
// khtg_pkg
// Shared types and constants for the knob hold-turn gesture block.
// ----------------------------------------------------------------------------
package khtg_pkg;

    localparam int MAX_TICKS = 63;
    localparam int TICK_W    = 7;
    localparam int CNT_W     = $clog2(MAX_TICKS + 1);
    localparam int CFG_W     = 16;
    localparam int TIME_W    = 32;
    localparam int PCNT_W    = 8;
    localparam int KEY_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [KEY_W-1:0] KEY_LEFT   = 8'd21;
    localparam logic [KEY_W-1:0] KEY_RIGHT  = 8'd22;
    localparam logic [KEY_W-1:0] KEY_CENTER = 8'd23;

    localparam logic [CFG_W-1:0] PRESS_WINDOW_RST   = 16'd400;
    localparam logic [CFG_W-1:0] RELEASE_WINDOW_RST = 16'd350;
    localparam logic [CFG_W-1:0] HOLD_CONTINUE_RST  = 16'd400;
    localparam logic [CFG_W-1:0] CLICK_BLOCK_RST    = 16'd400;

    typedef enum logic [1:0] {
        KIND_REPORT = 2'd0,
        KIND_NUDGE  = 2'd1,
        KIND_ROTARY = 2'd2,
        KIND_CENTER = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_WINDOW   = 2'd0,
        CFG_RELEASE_WINDOW = 2'd1,
        CFG_HOLD_CONTINUE  = 2'd2,
        CFG_CLICK_BLOCK    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] press_window;
        logic [CFG_W-1:0] release_window;
        logic [CFG_W-1:0] hold_continue;
        logic [CFG_W-1:0] click_block;
    } t_cfg;

    typedef struct packed {
        logic              prev_level;
        logic              turned_during_hold;
        logic [TIME_W-1:0] press_stamp;
        logic [TIME_W-1:0] release_stamp;
        logic [TIME_W-1:0] held_turn_stamp;
    } t_state;

    // results still owed for one poll
    typedef struct packed {
        logic                     valid;
        logic                     report;
        logic [CNT_W-1:0]         nudges;
        logic [KEY_W-1:0]         key;
        logic                     rotary;
        logic signed [TICK_W-1:0] ticks;
        logic                     pressed;
        logic                     center;
    } t_job;

endpackage

[rtl/core/khtg_decide.sv]
// ----------------------------------------------------------------------------
// khtg_decide
// Edge detection, hold classification, state update and result job for one poll.
// ----------------------------------------------------------------------------
module khtg_decide (
    input  logic signed [khtg_pkg::TICK_W-1:0] i_tick_count,
    input  logic                               i_button_level,
    input  logic [khtg_pkg::PCNT_W-1:0]        i_press_count,
    input  logic [khtg_pkg::TIME_W-1:0]        i_time_ms,
    input  logic                               i_projection_on,
    input  khtg_pkg::t_cfg                     i_cfg,
    input  khtg_pkg::t_state                   i_state,
    output khtg_pkg::t_state                   o_state,
    output khtg_pkg::t_job                     o_job
);
    import khtg_pkg::*;

    localparam logic signed [TICK_W:0] TMAX = (TICK_W+1)'(MAX_TICKS);

    logic signed [TICK_W:0]   ticks_wide;
    logic signed [TICK_W-1:0] ticks;
    logic [TICK_W-1:0]        ticks_mag;
    logic                     got_press;
    logic                     got_release;
    logic [TIME_W-1:0]        press_stamp;
    logic [TIME_W-1:0]        release_stamp;
    logic [TIME_W-1:0]        age_press;
    logic [TIME_W-1:0]        age_release;
    logic [TIME_W-1:0]        age_held;
    logic                     held;
    logic                     turning;
    logic                     held_turn;
    logic                     tdh;

    always_comb begin
        ticks_wide = {i_tick_count[TICK_W-1], i_tick_count};
        if (ticks_wide > TMAX) begin
            ticks_wide = TMAX;
        end else if (ticks_wide < -TMAX) begin
            ticks_wide = -TMAX;
        end
        ticks     = ticks_wide[TICK_W-1:0];
        ticks_mag = ticks[TICK_W-1] ? TICK_W'(-ticks) : TICK_W'(ticks);

        got_press   = |i_press_count;
        // a counted press with the button already up again is a fast tap
        got_release = !i_button_level && (i_state.prev_level || got_press);

        press_stamp   = got_press   ? i_time_ms : i_state.press_stamp;
        release_stamp = got_release ? i_time_ms : i_state.release_stamp;

        age_press   = i_time_ms - press_stamp;
        age_release = i_time_ms - release_stamp;
        age_held    = i_time_ms - i_state.held_turn_stamp;

        held = i_button_level
            || ((age_press < TIME_W'(i_cfg.press_window))
                && (age_release < TIME_W'(i_cfg.release_window)))
            || (age_held < TIME_W'(i_cfg.hold_continue));

        turning   = (ticks != '0);
        held_turn = i_projection_on && turning && held;

        tdh = i_state.turned_during_hold;
        if (got_press) begin
            tdh = 1'b0;
        end
        if (held_turn) begin
            tdh = 1'b1;
        end

        o_state.prev_level         = i_button_level;
        o_state.turned_during_hold = tdh;
        o_state.press_stamp        = press_stamp;
        o_state.release_stamp      = release_stamp;
        o_state.held_turn_stamp    = held_turn ? i_time_ms : i_state.held_turn_stamp;

        o_job.report  = !i_projection_on;
        o_job.nudges  = held_turn ? ticks_mag[CNT_W-1:0] : '0;
        o_job.key     = ticks[TICK_W-1] ? KEY_LEFT : KEY_RIGHT;
        o_job.rotary  = i_projection_on && turning && !held;
        o_job.ticks   = ticks;
        o_job.pressed = i_button_level || got_press;
        o_job.center  = i_projection_on && got_release && !tdh
                        && (age_held > TIME_W'(i_cfg.click_block));
        o_job.valid   = o_job.report || (o_job.nudges != '0) || o_job.rotary
                        || o_job.center;
    end

endmodule

[rtl/core/knob_hold_turn_gesture.sv]
// ----------------------------------------------------------------------------
// knob_hold_turn_gesture
// Turns rotary knob polls into nudge keys, rotary deltas, center keys or
// encoder reports.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one poll per beat: tdata holds tick_count, button_level,
//   press_count and time_ms, tuser holds projection_on.
//   m_axis carries the results of a poll, one per beat; tuser is the event
//   kind and tlast marks the final result of the poll. A quiet poll in
//   projection mode gives no beat at all.
//   Configuration: write i_cfg_wdata to register i_cfg_addr while i_cfg_we is
//   high; only while the block is idle.
// Timing:
//   a poll is held in the input register, is classified and turned into a
//   result job in the job register, and its results are registered in the
//   output register. The result emitter gives one beat per cycle while
//   m_axis_tready does not stall it; a poll gives 1 to 63 results, a quiet
//   poll in projection mode none. The next poll is taken while the last
//   result of the previous one is being emitted.
// Reset: clears the input, job and output valids, the gesture state and
//   loads the default windows.
// Stall: while m_axis_tready is low the output beat holds, the job and then
//   the input register fill, and s_axis_tready drops.
// ----------------------------------------------------------------------------
module knob_hold_turn_gesture (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // poll input
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // tick_count[6:0], button_level[7],
                                         // press_count[15:8], time_ms[47:16]
    input  logic        i_s_axis_tuser,  // projection_on
    // result output
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // key_code[7:0], rotary_delta[14:8],
                                         // report_diff[21:15],
                                         // report_pressed[22], zero[23]
    output logic [1:0]  o_m_axis_tuser,  // event_kind
    output logic        o_m_axis_tlast,  // last_of_run
    // configuration
    input  logic        i_cfg_we,
    input  logic [khtg_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [khtg_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import khtg_pkg::*;

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_job   r_job;
    t_job   n_job;
    t_job   dec_job;

    logic                     r_in_valid;
    logic signed [TICK_W-1:0] r_in_ticks;
    logic                     r_in_level;
    logic [PCNT_W-1:0]        r_in_pcnt;
    logic [TIME_W-1:0]        r_in_time;
    logic                     r_in_proj;

    logic                     r_out_valid;
    t_kind                    r_out_kind;
    logic [KEY_W-1:0]         r_out_key;
    logic signed [TICK_W-1:0] r_out_rot;
    logic signed [TICK_W-1:0] r_out_diff;
    logic                     r_out_pressed;
    logic                     r_out_last;

    t_kind                    e_kind;
    logic [KEY_W-1:0]         e_key;
    logic signed [TICK_W-1:0] e_rot;
    logic signed [TICK_W-1:0] e_diff;
    logic                     e_pressed;
    logic                     e_last;

    logic out_free;
    logic emit;
    logic job_free;
    logic proc;
    logic in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_window   <= PRESS_WINDOW_RST;
            r_cfg.release_window <= RELEASE_WINDOW_RST;
            r_cfg.hold_continue  <= HOLD_CONTINUE_RST;
            r_cfg.click_block    <= CLICK_BLOCK_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PRESS_WINDOW:   r_cfg.press_window   <= i_cfg_wdata;
                CFG_RELEASE_WINDOW: r_cfg.release_window <= i_cfg_wdata;
                CFG_HOLD_CONTINUE:  r_cfg.hold_continue  <= i_cfg_wdata;
                CFG_CLICK_BLOCK:    r_cfg.click_block    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign emit            = r_job.valid && out_free;
    assign job_free        = !r_job.valid || (emit && e_last);
    assign proc            = r_in_valid && job_free;
    assign o_s_axis_tready = !r_in_valid || proc;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_ticks <= i_s_axis_tdata[6:0];
            r_in_level <= i_s_axis_tdata[7];
            r_in_pcnt  <= i_s_axis_tdata[15:8];
            r_in_time  <= i_s_axis_tdata[47:16];
            r_in_proj  <= i_s_axis_tuser;
        end
    end

    khtg_decide u_decide (
        .i_tick_count    (r_in_ticks),
        .i_button_level  (r_in_level),
        .i_press_count   (r_in_pcnt),
        .i_time_ms       (r_in_time),
        .i_projection_on (r_in_proj),
        .i_cfg           (r_cfg),
        .i_state         (r_state),
        .o_state         (n_state),
        .o_job           (dec_job)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    // result emitter: report, then nudges, then rotary delta, then center key
    always_comb begin
        n_job     = r_job;
        e_kind    = KIND_CENTER;
        e_key     = KEY_CENTER;
        e_rot     = '0;
        e_diff    = '0;
        e_pressed = 1'b0;
        e_last    = 1'b1;
        priority if (r_job.report) begin
            e_kind    = KIND_REPORT;
            e_key     = '0;
            e_diff    = r_job.ticks;
            e_pressed = r_job.pressed;
        end else if (r_job.nudges != '0) begin
            e_kind       = KIND_NUDGE;
            e_key        = r_job.key;
            e_last       = (r_job.nudges == CNT_W'(1)) && !r_job.rotary && !r_job.center;
            n_job.nudges = r_job.nudges - CNT_W'(1);
        end else if (r_job.rotary) begin
            e_kind       = KIND_ROTARY;
            e_key        = '0;
            e_rot        = r_job.ticks;
            e_last       = !r_job.center;
            n_job.rotary = 1'b0;
        end else begin
            e_kind = KIND_CENTER;
        end
        if (e_last) begin
            n_job.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job <= '0;
        end else if (proc) begin
            r_job <= dec_job;
        end else if (emit) begin
            r_job <= n_job;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind    <= e_kind;
            r_out_key     <= e_key;
            r_out_rot     <= e_rot;
            r_out_diff    <= e_diff;
            r_out_pressed <= e_pressed;
            r_out_last    <= e_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_pressed, r_out_diff, r_out_rot, r_out_key};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

endmodule

[rtl/core/khtg_checker.sv]
// ----------------------------------------------------------------------------
// khtg_checker
// Port-level checks for the knob hold-turn gesture block.
// ----------------------------------------------------------------------------
module khtg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);
    import khtg_pkg::*;

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("output beat changed under stall");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // a report is always the single result of its poll
    a_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_REPORT) |->
            o_m_axis_tlast && (o_m_axis_tdata[14:0] == 15'd0))
        else $error("bad encoder report beat");

    a_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_CENTER) |->
            o_m_axis_tlast && (o_m_axis_tdata == {16'd0, KEY_CENTER}))
        else $error("bad center key beat");

    a_nudge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_NUDGE) |->
            ((o_m_axis_tdata[7:0] == KEY_LEFT) || (o_m_axis_tdata[7:0] == KEY_RIGHT))
            && (o_m_axis_tdata[23:8] == 16'd0))
        else $error("bad nudge key beat");

endmodule

bind knob_hold_turn_gesture khtg_checker u_khtg_checker (.*);
